FILE: sv/kle_pkg.sv
package kle_pkg;

  localparam int LINE_DEPTH = 32;
  localparam int COUNT_W    = $clog2(LINE_DEPTH);
  localparam int LIMIT_W    = 6;
  localparam int KEY_W      = 8;
  localparam int LEN_W      = 5;
  localparam int KIND_W     = 2;
  localparam int OUT_DATA_W = ((KEY_W + LEN_W + 7) / 8) * 8;

  localparam logic [LIMIT_W-1:0] LIMIT_MIN   = LIMIT_W'(2);
  localparam logic [LIMIT_W-1:0] LIMIT_MAX   = LIMIT_W'(LINE_DEPTH);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(32);

  localparam logic [KEY_W-1:0] KEY_NEWLINE   = 8'd10;
  localparam logic [KEY_W-1:0] KEY_RUBOUT    = 8'd8;
  localparam logic [KEY_W-1:0] KEY_BLANK     = 8'd32;
  localparam logic [KEY_W-1:0] KEY_PRINT_LO  = 8'd32;
  localparam logic [KEY_W-1:0] KEY_PRINT_HI  = 8'd126;

  typedef enum logic [KIND_W-1:0] {
    KIND_ECHO = 2'd0,
    KIND_CHAR = 2'd1,
    KIND_END  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    EMIT_KEY,
    EMIT_NEWLINE,
    EMIT_BACKSPACE,
    EMIT_SPACE,
    EMIT_CHAR,
    EMIT_END
  } emit_sel_t;

  typedef struct packed {
    logic      latch_sample;
    logic      hold_update;
    logic      latch_key;
    logic      store_key;
    logic      dec_count;
    logic      clr_count;
    logic      clr_idx;
    logic      inc_idx;
    logic      emit;
    emit_sel_t emit_sel;
    logic      emit_last;
  } cmd_t;

  typedef struct packed {
    logic await_release;
    logic sample_eq_held;
    logic count_ge_cap;
    logic count_zero;
    logic held_is_newline;
    logic held_is_backspace;
    logic held_is_print;
    logic idx_lt_count;
    logic out_free;
  } status_t;

endpackage

FILE: sv/keyboard_line_editor.sv
// Keyboard line editor.
// s_axis carries one keyboard poll per request (tdata: key_sample). A key
// counts as typed when its code is followed by a different value. Typed
// keys give echo items, backspace handling and, at line end, the stored
// line followed by an end item.
// m_axis carries the results: tdata holds char_code then line_length,
// tuser holds item_kind, tlast marks the final result of one poll.
// cfg_valid/cfg_data write line_limit (6 bits); cfg_ready is always high.
// Write it only while the block is idle.
// A poll is accepted and then evaluated; its results are then loaded one
// after another. A line end with n characters gives n + 1 results, up to
// 33 with an echo. One sequencer drives one output register, so the block
// accepts the next poll only after the last result of the current one is
// loaded into that register.
// When m_axis_tready is low the result holds in the output register and
// the sequencer waits.
// Reset (rst, synchronous) empties the line, clears the held key, sets
// line_limit to 32 and drops any pending result.
module keyboard_line_editor (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,   // key_sample
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [kle_pkg::OUT_DATA_W-1:0]     m_axis_tdata,   // char_code, line_length
  output logic [kle_pkg::KIND_W-1:0]         m_axis_tuser,   // item_kind
  output logic                               m_axis_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [kle_pkg::LIMIT_W-1:0]        cfg_data
);

  kle_pkg::cmd_t    cmd;
  kle_pkg::status_t status;

  logic [kle_pkg::KEY_W-1:0] out_code;
  logic [kle_pkg::LEN_W-1:0] out_len;

  assign cfg_ready = 1'b1;
  assign m_axis_tdata = kle_pkg::OUT_DATA_W'({out_len, out_code});

  kle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  kle_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .sample_in (s_axis_tdata),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_kind  (m_axis_tuser),
    .out_code  (out_code),
    .out_len   (out_len),
    .out_last  (m_axis_tlast)
  );

endmodule

FILE: sv/kle_datapath.sv
module kle_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  kle_pkg::cmd_t                        cmd,
  output kle_pkg::status_t                     status,
  input  logic [kle_pkg::KEY_W-1:0]            sample_in,
  input  logic                                 cfg_valid,
  input  logic [kle_pkg::LIMIT_W-1:0]          cfg_data,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic [kle_pkg::KIND_W-1:0]           out_kind,
  output logic [kle_pkg::KEY_W-1:0]            out_code,
  output logic [kle_pkg::LEN_W-1:0]            out_len,
  output logic                                 out_last
);

  logic [kle_pkg::LIMIT_W-1:0] line_limit;
  logic [kle_pkg::KEY_W-1:0]   sample;
  logic [kle_pkg::KEY_W-1:0]   held_key;
  logic                        await_release;
  logic [kle_pkg::KEY_W-1:0]   key;
  logic [kle_pkg::COUNT_W-1:0] char_count;
  logic [kle_pkg::COUNT_W-1:0] idx;
  logic [kle_pkg::KEY_W-1:0]   line_store [kle_pkg::LINE_DEPTH];

  logic [kle_pkg::LIMIT_W-1:0] eff_limit;
  logic [kle_pkg::LIMIT_W-1:0] cap;
  logic [kle_pkg::KIND_W-1:0]  kind_next;
  logic [kle_pkg::KEY_W-1:0]   code_next;
  logic [kle_pkg::LEN_W-1:0]   len_next;

  always_comb begin
    if (line_limit < kle_pkg::LIMIT_MIN) begin
      eff_limit = kle_pkg::LIMIT_MIN;
    end else if (line_limit > kle_pkg::LIMIT_MAX) begin
      eff_limit = kle_pkg::LIMIT_MAX;
    end else begin
      eff_limit = line_limit;
    end
    cap = eff_limit - kle_pkg::LIMIT_W'(1);
  end

  always_comb begin
    status.await_release     = await_release;
    status.sample_eq_held    = (sample == held_key);
    status.count_ge_cap      = (kle_pkg::LIMIT_W'(char_count) >= cap);
    status.count_zero        = (char_count == '0);
    status.held_is_newline   = (held_key == kle_pkg::KEY_NEWLINE);
    status.held_is_backspace = (held_key == kle_pkg::KEY_RUBOUT);
    status.held_is_print     = (held_key >= kle_pkg::KEY_PRINT_LO) &&
                               (held_key <= kle_pkg::KEY_PRINT_HI);
    status.idx_lt_count      = (idx < char_count);
    status.out_free          = !out_valid || out_ready;
  end

  always_comb begin
    kind_next = kle_pkg::KIND_ECHO;
    code_next = key;
    len_next  = kle_pkg::LEN_W'(char_count);
    unique case (cmd.emit_sel)
      kle_pkg::EMIT_KEY:       code_next = key;
      kle_pkg::EMIT_NEWLINE:   code_next = kle_pkg::KEY_NEWLINE;
      kle_pkg::EMIT_BACKSPACE: code_next = kle_pkg::KEY_RUBOUT;
      kle_pkg::EMIT_SPACE:     code_next = kle_pkg::KEY_BLANK;
      kle_pkg::EMIT_CHAR: begin
        kind_next = kle_pkg::KIND_CHAR;
        code_next = line_store[idx];
        len_next  = kle_pkg::LEN_W'(idx);
      end
      kle_pkg::EMIT_END: begin
        kind_next = kle_pkg::KIND_END;
        code_next = '0;
      end
      default: code_next = key;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_limit    <= kle_pkg::LIMIT_RESET;
      held_key      <= '0;
      await_release <= 1'b0;
      char_count    <= '0;
      idx           <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        line_limit <= cfg_data;
      end
      if (cmd.hold_update) begin
        held_key      <= sample;
        await_release <= (sample != '0);
      end
      if (cmd.store_key) begin
        char_count <= char_count + kle_pkg::COUNT_W'(1);
      end else if (cmd.dec_count) begin
        char_count <= char_count - kle_pkg::COUNT_W'(1);
      end else if (cmd.clr_count) begin
        char_count <= '0;
      end
      if (cmd.clr_idx) begin
        idx <= '0;
      end else if (cmd.inc_idx) begin
        idx <= idx + kle_pkg::COUNT_W'(1);
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_sample) begin
      sample <= sample_in;
    end
    if (cmd.latch_key) begin
      key <= held_key;
    end
    if (cmd.store_key) begin
      line_store[char_count] <= held_key;
    end
    if (cmd.emit) begin
      out_kind <= kind_next;
      out_code <= code_next;
      out_len  <= len_next;
      out_last <= cmd.emit_last;
    end
  end

endmodule

FILE: sv/kle_ctrl.sv
module kle_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  kle_pkg::status_t  status,
  output kle_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_PRINT,
    S_NEWLINE,
    S_BS1,
    S_SPACE,
    S_BS2,
    S_LINE
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.emit_sel = kle_pkg::EMIT_KEY;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_sample = 1'b1;
          state_next       = S_EVAL;
        end
      end
      S_EVAL: begin
        state_next = S_IDLE;
        if (!status.await_release || !status.sample_eq_held) begin
          cmd.hold_update = 1'b1;
        end
        if (status.await_release && !status.sample_eq_held) begin
          cmd.latch_key = 1'b1;
          cmd.clr_idx   = 1'b1;
          if (status.count_ge_cap) begin
            state_next = S_LINE;
          end else if (status.held_is_newline) begin
            state_next = S_NEWLINE;
          end else if (status.held_is_backspace) begin
            if (!status.count_zero) begin
              cmd.dec_count = 1'b1;
              state_next    = S_BS1;
            end
          end else if (status.held_is_print) begin
            cmd.store_key = 1'b1;
            state_next    = S_PRINT;
          end
        end
      end
      S_PRINT: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = kle_pkg::EMIT_KEY;
          cmd.emit_last = !status.count_ge_cap;
          state_next    = status.count_ge_cap ? S_LINE : S_IDLE;
        end
      end
      S_NEWLINE: begin
        if (status.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = kle_pkg::EMIT_NEWLINE;
          state_next   = S_LINE;
        end
      end
      S_BS1: begin
        if (status.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = kle_pkg::EMIT_BACKSPACE;
          state_next   = S_SPACE;
        end
      end
      S_SPACE: begin
        if (status.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = kle_pkg::EMIT_SPACE;
          state_next   = S_BS2;
        end
      end
      S_BS2: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = kle_pkg::EMIT_BACKSPACE;
          cmd.emit_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_LINE: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.idx_lt_count) begin
            cmd.emit_sel = kle_pkg::EMIT_CHAR;
            cmd.inc_idx  = 1'b1;
          end else begin
            cmd.emit_sel  = kle_pkg::EMIT_END;
            cmd.emit_last = 1'b1;
            cmd.clr_count = 1'b1;
            state_next    = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: tb/sv/line_editor_checker.sv
`timescale 1ns / 100ps
module line_editor_checker
  import kle_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_valid,
  input  logic                  s_ready,
  input  logic [KEY_W-1:0]      s_data,
  input  logic                  m_valid,
  input  logic                  m_ready,
  input  logic [OUT_DATA_W-1:0] m_data,
  input  logic [KIND_W-1:0]     m_user,
  input  logic                  m_last,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [LIMIT_W-1:0]    cfg_data,
  output int                    errors,
  output int                    pending
);

  typedef struct packed {
    kind_t            kind;
    logic [KEY_W-1:0] code;
    logic [LEN_W-1:0] len;
    logic             last;
  } line_item_t;

  line_item_t         due_items[$];
  logic [LIMIT_W-1:0] line_limit;
  logic               pressed;
  logic [KEY_W-1:0]   held;
  int                 count;
  logic [KEY_W-1:0]   line_buf [LINE_DEPTH];

  function automatic void post(kind_t kind, logic [KEY_W-1:0] code, int len);
    line_item_t item;
    item = '{kind, code, LEN_W'(len), 1'b0};
    due_items.push_back(item);
  endfunction

  function automatic void close_line();
    for (int i = 0; i < count && i < LINE_DEPTH; i++) begin
      post(KIND_CHAR, line_buf[i], i);
    end
    post(KIND_END, '0, count);
    count = 0;
  endfunction

  function automatic void apply_key(logic [KEY_W-1:0] key);
    int lim;
    lim = int'(line_limit);
    if (lim < int'(LIMIT_MIN)) lim = int'(LIMIT_MIN);
    if (lim > int'(LIMIT_MAX)) lim = int'(LIMIT_MAX);
    if (count >= lim - 1) begin
      close_line();
      return;
    end
    if (key == KEY_NEWLINE) begin
      post(KIND_ECHO, KEY_NEWLINE, count);
      close_line();
    end else if (key == KEY_RUBOUT) begin
      if (count > 0) begin
        count--;
        post(KIND_ECHO, KEY_RUBOUT, count);
        post(KIND_ECHO, KEY_BLANK, count);
        post(KIND_ECHO, KEY_RUBOUT, count);
      end
    end else if (key >= KEY_PRINT_LO && key <= KEY_PRINT_HI) begin
      if (count < LINE_DEPTH) line_buf[count] = key;
      count++;
      post(KIND_ECHO, key, count);
      if (count >= lim - 1) close_line();
    end
  endfunction

  function automatic void apply_poll(logic [KEY_W-1:0] sample);
    int         queued;
    line_item_t tail;
    if (!pressed) begin
      if (sample != '0) begin
        held = sample;
        pressed = 1'b1;
      end
      return;
    end
    if (sample == held) return;
    queued = due_items.size();
    apply_key(held);
    held = sample;
    pressed = (sample != '0);
    if (due_items.size() > queued) begin
      tail = due_items.pop_back();
      tail.last = 1'b1;
      due_items.push_back(tail);
    end
  endfunction

  always @(posedge clk) begin
    line_item_t want;
    line_item_t got;
    if (rst) begin
      due_items.delete();
      line_limit = LIMIT_RESET;
      pressed = 1'b0;
      held = '0;
      count = 0;
      errors = 0;
    end else begin
      if (m_valid && m_ready) begin
        got = '{kind_t'(m_user), m_data[KEY_W-1:0], m_data[KEY_W +: LEN_W], m_last};
        if (due_items.size() == 0) begin
          errors++;
          $display("%0t: result with none due: kind %0d code %0h len %0d last %0b",
                   $time, got.kind, got.code, got.len, got.last);
        end else begin
          want = due_items.pop_front();
          if (got !== want || m_data[OUT_DATA_W-1:KEY_W+LEN_W] !== '0) begin
            errors++;
            $display({"%0t: mismatch: expected kind %0d code %0h len %0d last %0b,",
                      " got kind %0d code %0h len %0d last %0b tdata %0h"},
                     $time, want.kind, want.code, want.len, want.last,
                     got.kind, got.code, got.len, got.last, m_data);
          end
        end
      end
      if (cfg_valid && cfg_ready) line_limit = cfg_data;
      if (s_valid && s_ready) apply_poll(s_data);
    end
    pending <= due_items.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import kle_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 20;
  localparam int PHASES        = 7;
  localparam int OPENING_LEN   = 16;

  typedef enum int {PACE_FULL, PACE_SEND_GAPS, PACE_STALLS, PACE_BOTH} pace_t;

  localparam logic [KEY_W-1:0] OPENING_KEYS [OPENING_LEN] = '{
    8'd0, "A", "A", 8'd0, 8'd255, KEY_RUBOUT, 8'd0, KEY_RUBOUT, 8'd0,
    8'd127, 8'd1, KEY_PRINT_HI, KEY_BLANK, KEY_NEWLINE, 8'd0, 8'd128
  };
  localparam logic [LIMIT_W-1:0] PHASE_LIMIT [PHASES] = '{
    6'd0, 6'd63, 6'd33, 6'd1, 6'd32, 6'd0, 6'd0
  };
  localparam pace_t PHASE_PACE [PHASES] = '{
    PACE_FULL, PACE_SEND_GAPS, PACE_STALLS, PACE_BOTH, PACE_FULL, PACE_SEND_GAPS, PACE_STALLS
  };
  localparam int PHASE_POLLS [PHASES] = '{20, 25, 25, 15, 64, 25, 25};

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [KEY_W-1:0]      s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [KIND_W-1:0]     m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [LIMIT_W-1:0]    cfg_data = '0;

  int gap_pct = 0;
  int stall_pct = 0;
  int polls_sent = 0;
  int idle_cycles = 0;
  int errors;
  int pending;

  keyboard_line_editor dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  line_editor_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .s_valid   (s_axis_tvalid),
    .s_ready   (s_axis_tready),
    .s_data    (s_axis_tdata),
    .m_valid   (m_axis_tvalid),
    .m_ready   (m_axis_tready),
    .m_data    (m_axis_tdata),
    .m_user    (m_axis_tuser),
    .m_last    (m_axis_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic void set_pace(pace_t pace);
    case (pace)
      PACE_FULL: begin
        gap_pct = 0;
        stall_pct = 0;
      end
      PACE_SEND_GAPS: begin
        gap_pct = 74;
        stall_pct = 0;
      end
      PACE_STALLS: begin
        gap_pct = 0;
        stall_pct = 74;
      end
      default: begin
        gap_pct = 6;
        stall_pct = 6;
      end
    endcase
  endfunction

  task automatic send(input logic [KEY_W-1:0] key);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < gap_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= key;
    do @(posedge clk); while (!s_axis_tready);
    polls_sent++;
  endtask

  // hold off until every due result has been taken, then let the block settle
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [KEY_W-1:0] pick_key(input bit plain);
    int roll;
    roll = $urandom_range(0, 99);
    if (plain || roll < 60) return KEY_W'($urandom_range(int'(KEY_PRINT_LO), int'(KEY_PRINT_HI)));
    if (roll < 72) return KEY_RUBOUT;
    if (roll < 80) return KEY_NEWLINE;
    if (roll < 90) return KEY_W'($urandom_range(0, int'(KEY_PRINT_LO) - 1));
    return KEY_W'($urandom_range(int'(KEY_PRINT_HI) + 1, 255));
  endfunction

  // one key press: hold for a few polls, then release or roll over to the next key
  task automatic press(input bit plain);
    logic [KEY_W-1:0] key;
    key = pick_key(plain);
    repeat (plain ? 1 : $urandom_range(1, 3)) send(key);
    if ($urandom_range(0, 99) < (plain ? 30 : 65)) begin
      repeat ($urandom_range(1, 2)) send('0);
    end
  endtask

  initial begin
    int target;
    set_pace(PACE_FULL);
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < OPENING_LEN; i++) send(OPENING_KEYS[i]);
    write_limit(LIMIT_MIN);
    send("x");
    send('0);
    write_limit(LIMIT_RESET);
    send("a");
    send('0);
    send("b");
    send('0);
    send("c");
    send('0);
    // lower the limit to the current line length
    write_limit(6'd3);
    send("z");
    send('0);

    for (int p = 0; p < PHASES; p++) begin
      write_limit(p >= 5 ? LIMIT_W'($urandom_range(0, 63)) : PHASE_LIMIT[p]);
      set_pace(PHASE_PACE[p]);
      target = polls_sent + PHASE_POLLS[p];
      while (polls_sent < target) begin
        press(p == 4);
        if (p == 1 && polls_sent >= target - PHASE_POLLS[p] / 2 && polls_sent < target - 2) begin
          settle();
          target = target - 3;
        end
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

FILE: keyboard_line_editor.f
sv/kle_pkg.sv
sv/kle_datapath.sv
sv/kle_ctrl.sv
sv/keyboard_line_editor.sv
tb/sv/line_editor_checker.sv
tb/sv/tb_top.sv
